// ===== sv/rrpc_pkg.sv =====
// Package: widths, register indexes, shape codes and reset values of the region classifier.
package rrpc_pkg;

	localparam int COORD_W  = 32;
	localparam int TAG_W    = 24;
	localparam int RECIP_W  = 48;
	localparam int ROT_W    = 32;
	localparam int TRIG_W   = 16;
	localparam int SHAPE_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam int PIPE_DEPTH = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SHAPE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_X  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Y  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Z  = 3'd7;

	localparam logic [SHAPE_W-1:0] SHAPE_ELLIPSOID = 2'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_BOX       = 2'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_CYLINDER  = 2'd2;

	localparam logic [ROT_W-1:0]   ROT_RESET   = 32'h4000_0000;
	localparam logic [RECIP_W-1:0] RECIP_RESET = 48'd281474976711;

	localparam logic [59:0] ONE_Q24 = 60'd1 << 24;
	localparam logic [51:0] ONE_Q48 = 52'd1 << 48;

endpackage

// ===== sv/rrpc_if.sv =====
// Interfaces: point input, classification result and configuration write channels.
interface rrpc_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [rrpc_pkg::COORD_W-1:0] point_x;
	logic signed [rrpc_pkg::COORD_W-1:0] point_y;
	logic signed [rrpc_pkg::COORD_W-1:0] point_z;
	logic        [rrpc_pkg::TAG_W-1:0]   element_tag;

	modport source (output valid, point_x, point_y, point_z, element_tag, input ready);
	modport sink   (input valid, point_x, point_y, point_z, element_tag, output ready);
endinterface

interface rrpc_result_if;
	logic                        valid;
	logic                        ready;
	logic                        inside_res;
	logic [rrpc_pkg::TAG_W-1:0]  tag_out;

	modport source (output valid, inside_res, tag_out, input ready);
	modport sink   (input valid, inside_res, tag_out, output ready);
endinterface

interface rrpc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rrpc_pkg::CFG_IDX_W-1:0]    index;
	logic [rrpc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rotated_region_point_classifier.sv =====
// Top level: pipelined point-in-region test for an oriented ellipsoid, box or cylinder.
// Takes one point per clock while the result side does not stall, and returns one result per
// point, in order. The pipeline has eight register stages: offset subtract, rotation multiply,
// rotation sum and floor shift, magnitude, scale multiply (two 24-bit halves of each
// reciprocal), scale sum and unit compare, squaring, and the final sum compare that feeds the
// output register. Each stage holds its item while the stage after it is full and stalled, so
// input ready falls only when all eight stages hold items and the result is not taken. The
// configuration registers feed several stages directly, so write them only while no
// transaction is in flight.
module rotated_region_point_classifier (
	input  logic                 clk,
	input  logic                 arst_n,
	rrpc_cfg_if.sink             cfg,
	rrpc_point_if.sink           point,
	rrpc_result_if.source        result
);

	localparam int NSTG = rrpc_pkg::PIPE_DEPTH;

	// configuration registers
	logic [rrpc_pkg::SHAPE_W-1:0]        shape_q;
	logic signed [rrpc_pkg::COORD_W-1:0] centre_x_q, centre_y_q, centre_z_q;
	logic [rrpc_pkg::ROT_W-1:0]          rot_q;
	logic [rrpc_pkg::RECIP_W-1:0]        recip_x_q, recip_y_q, recip_z_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q    <= rrpc_pkg::SHAPE_ELLIPSOID;
			centre_x_q <= '0;
			centre_y_q <= '0;
			centre_z_q <= '0;
			rot_q      <= rrpc_pkg::ROT_RESET;
			recip_x_q  <= rrpc_pkg::RECIP_RESET;
			recip_y_q  <= rrpc_pkg::RECIP_RESET;
			recip_z_q  <= rrpc_pkg::RECIP_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				rrpc_pkg::REG_SHAPE:    shape_q    <= cfg.data[rrpc_pkg::SHAPE_W-1:0];
				rrpc_pkg::REG_CENTRE_X: centre_x_q <= signed'(cfg.data[31:0]);
				rrpc_pkg::REG_CENTRE_Y: centre_y_q <= signed'(cfg.data[31:0]);
				rrpc_pkg::REG_CENTRE_Z: centre_z_q <= signed'(cfg.data[31:0]);
				rrpc_pkg::REG_ROTATION: rot_q      <= cfg.data[31:0];
				rrpc_pkg::REG_RECIP_X:  recip_x_q  <= cfg.data;
				rrpc_pkg::REG_RECIP_Y:  recip_y_q  <= cfg.data;
				rrpc_pkg::REG_RECIP_Z:  recip_z_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	logic signed [rrpc_pkg::TRIG_W-1:0] cos_w, sin_w;
	assign cos_w = signed'(rot_q[31:16]);
	assign sin_w = signed'(rot_q[15:0]);

	// stage handshake: a stage loads when it is empty or the next stage loads
	logic [NSTG:1] vld;
	logic [NSTG:1] adv;

	always_comb begin
		adv[NSTG] = !vld[NSTG] || result.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign point.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) vld[1] <= point.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) vld[k] <= vld[k-1];
			end
		end
	end

	// tag line
	logic [rrpc_pkg::TAG_W-1:0] tag_s [1:NSTG];

	always_ff @(posedge clk) begin
		if (adv[1]) tag_s[1] <= point.element_tag;
		for (int k = 2; k <= NSTG; k++) begin
			if (adv[k]) tag_s[k] <= tag_s[k-1];
		end
	end

	// s1: offset from centre
	logic signed [32:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dx_s1 <= 33'(point.point_x) - 33'(centre_x_q);
			dy_s1 <= 33'(point.point_y) - 33'(centre_y_q);
			dz_s1 <= 33'(point.point_z) - 33'(centre_z_q);
		end
	end

	// s2: rotation products
	logic signed [48:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [32:0] dz_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pxc_s2 <= dx_s1 * cos_w;
			pys_s2 <= dy_s1 * sin_w;
			pyc_s2 <= dy_s1 * cos_w;
			pxs_s2 <= dx_s1 * sin_w;
			dz_s2  <= dz_s1;
		end
	end

	// s3: rotation sums, floor shift by 14
	logic signed [49:0] sum_x, sum_y;
	logic signed [35:0] rx_s3, ry_s3;
	logic signed [32:0] dz_s3;

	always_comb begin
		sum_x = 50'(pxc_s2) + 50'(pys_s2);
		sum_y = 50'(pyc_s2) - 50'(pxs_s2);
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			rx_s3 <= 36'(sum_x >>> 14);
			ry_s3 <= 36'(sum_y >>> 14);
			dz_s3 <= dz_s2;
		end
	end

	// s4: magnitudes
	logic [34:0] mag_x_s4, mag_y_s4;
	logic [32:0] mag_z_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			mag_x_s4 <= rx_s3[35] ? 35'(-rx_s3) : 35'(rx_s3);
			mag_y_s4 <= ry_s3[35] ? 35'(-ry_s3) : 35'(ry_s3);
			mag_z_s4 <= dz_s3[32] ? 33'(-dz_s3) : 33'(dz_s3);
		end
	end

	// s5: scale partial products, reciprocal split in 24-bit halves
	logic [58:0] phx_s5, plx_s5, phy_s5, ply_s5;
	logic [56:0] phz_s5, plz_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			phx_s5 <= mag_x_s4 * recip_x_q[47:24];
			plx_s5 <= mag_x_s4 * recip_x_q[23:0];
			phy_s5 <= mag_y_s4 * recip_y_q[47:24];
			ply_s5 <= mag_y_s4 * recip_y_q[23:0];
			phz_s5 <= mag_z_s4 * recip_z_q[47:24];
			plz_s5 <= mag_z_s4 * recip_z_q[23:0];
		end
	end

	// s6: scaled Q24 magnitudes, unit compare
	logic [59:0] m_x, m_y, m_z;
	logic [24:0] mx_s6, my_s6, mz_s6;
	logic        okx_s6, oky_s6, okz_s6;

	always_comb begin
		m_x = 60'(phx_s5) + 60'(plx_s5 >> 24);
		m_y = 60'(phy_s5) + 60'(ply_s5 >> 24);
		m_z = 60'(phz_s5) + 60'(plz_s5 >> 24);
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			mx_s6  <= m_x[24:0];
			my_s6  <= m_y[24:0];
			mz_s6  <= m_z[24:0];
			okx_s6 <= m_x <= rrpc_pkg::ONE_Q24;
			oky_s6 <= m_y <= rrpc_pkg::ONE_Q24;
			okz_s6 <= m_z <= rrpc_pkg::ONE_Q24;
		end
	end

	// s7: squares
	logic [49:0] sqx_s7, sqy_s7, sqz_s7;
	logic        ok_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			sqx_s7 <= mx_s6 * mx_s6;
			sqy_s7 <= my_s6 * my_s6;
			sqz_s7 <= mz_s6 * mz_s6;
			ok_s7  <= okx_s6 && oky_s6 && okz_s6;
		end
	end

	// s8: region decision, output register
	logic [51:0] sum_xy, sum_xyz;
	logic        inside_w;
	logic        inside_s8;

	always_comb begin
		sum_xy  = 52'(sqx_s7) + 52'(sqy_s7);
		sum_xyz = sum_xy + 52'(sqz_s7);
		case (shape_q)
			rrpc_pkg::SHAPE_ELLIPSOID: inside_w = ok_s7 && (sum_xyz <= rrpc_pkg::ONE_Q48);
			rrpc_pkg::SHAPE_BOX:       inside_w = ok_s7;
			rrpc_pkg::SHAPE_CYLINDER:  inside_w = ok_s7 && (sum_xy <= rrpc_pkg::ONE_Q48);
			default:                   inside_w = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[8]) inside_s8 <= inside_w;
	end

	assign result.valid      = vld[NSTG];
	assign result.inside_res = inside_s8;
	assign result.tag_out    = tag_s[NSTG];

endmodule

// ===== sv/rrpc_checker.sv =====
// Checker: port-level assertions for the region classifier, bound to the top level.
module rrpc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [rrpc_pkg::TAG_W-1:0] in_tag,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       out_inside,
	input logic [rrpc_pkg::TAG_W-1:0] out_tag
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_inside))
		else $error("result changed while stalled");

	// backpressure only when a finished result is waiting
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// with the result side ready while a point passes through, its result comes out carrying its tag
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
			##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid && out_tag == $past(in_tag, rrpc_pkg::PIPE_DEPTH))
		else $error("result missing or tag mismatch after pipeline latency");

endmodule

bind rotated_region_point_classifier rrpc_checker u_rrpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (point.valid),
	.in_ready   (point.ready),
	.in_tag     (point.element_tag),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_inside (result.inside_res),
	.out_tag    (result.tag_out)
);

// ===== tb/tb_top.sv =====
// Testbench: streams points through the region classifier and checks every verdict in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rrpc_pkg::SHAPE_W-1:0] SHAPE_UNUSED = 2'd3;

	typedef struct {
		logic                       in_region;
		logic [rrpc_pkg::TAG_W-1:0] tag;
	} verdict_t;

	class verdict_board_t;
		logic [rrpc_pkg::SHAPE_W-1:0]        shape;
		logic signed [rrpc_pkg::COORD_W-1:0] cen_x, cen_y, cen_z;
		logic [rrpc_pkg::ROT_W-1:0]          rot;
		logic [rrpc_pkg::RECIP_W-1:0]        recip_x, recip_y, recip_z;
		verdict_t                            awaited[$];
		int                                  errors;

		function new();
			shape   = rrpc_pkg::SHAPE_ELLIPSOID;
			cen_x   = '0;
			cen_y   = '0;
			cen_z   = '0;
			rot     = rrpc_pkg::ROT_RESET;
			recip_x = rrpc_pkg::RECIP_RESET;
			recip_y = rrpc_pkg::RECIP_RESET;
			recip_z = rrpc_pkg::RECIP_RESET;
			errors  = 0;
		endfunction

		task report(string msg);
			$display("tb_top mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(logic [rrpc_pkg::CFG_IDX_W-1:0] idx,
				logic [rrpc_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				rrpc_pkg::REG_SHAPE:    shape   = val[rrpc_pkg::SHAPE_W-1:0];
				rrpc_pkg::REG_CENTRE_X: cen_x   = val[rrpc_pkg::COORD_W-1:0];
				rrpc_pkg::REG_CENTRE_Y: cen_y   = val[rrpc_pkg::COORD_W-1:0];
				rrpc_pkg::REG_CENTRE_Z: cen_z   = val[rrpc_pkg::COORD_W-1:0];
				rrpc_pkg::REG_ROTATION: rot     = val[rrpc_pkg::ROT_W-1:0];
				rrpc_pkg::REG_RECIP_X:  recip_x = val[rrpc_pkg::RECIP_W-1:0];
				rrpc_pkg::REG_RECIP_Y:  recip_y = val[rrpc_pkg::RECIP_W-1:0];
				rrpc_pkg::REG_RECIP_Z:  recip_z = val[rrpc_pkg::RECIP_W-1:0];
				default: ;
			endcase
		endfunction

		// floor(|r| * recip / 2^24), exact at full width
		function bit [63:0] scaled(longint r, logic [rrpc_pkg::RECIP_W-1:0] recip);
			bit [63:0]  mag;
			bit [127:0] prod;
			mag  = (r < 0) ? -r : r;
			prod = 128'(mag) * 128'(recip);
			return prod[87:24];
		endfunction

		function logic predict_inside(logic signed [rrpc_pkg::COORD_W-1:0] px, py, pz);
			longint    dx, dy, dz, c, s, rx, ry;
			bit [63:0] mx, my, mz;
			bit        unit_ok;
			dx = longint'(px) - longint'(cen_x);
			dy = longint'(py) - longint'(cen_y);
			dz = longint'(pz) - longint'(cen_z);
			c  = longint'($signed(rot[31:16]));
			s  = longint'($signed(rot[15:0]));
			rx = (dx * c + dy * s) >>> 14;
			ry = (dy * c - dx * s) >>> 14;
			mx = scaled(rx, recip_x);
			my = scaled(ry, recip_y);
			mz = scaled(dz, recip_z);
			unit_ok = (mx <= rrpc_pkg::ONE_Q24) && (my <= rrpc_pkg::ONE_Q24) &&
				(mz <= rrpc_pkg::ONE_Q24);
			case (shape)
				rrpc_pkg::SHAPE_ELLIPSOID:
					return unit_ok && (mx * mx + my * my + mz * mz <= rrpc_pkg::ONE_Q48);
				rrpc_pkg::SHAPE_BOX:
					return unit_ok;
				rrpc_pkg::SHAPE_CYLINDER:
					return unit_ok && (mx * mx + my * my <= rrpc_pkg::ONE_Q48);
				default:
					return 1'b0;
			endcase
		endfunction

		function void note_point(logic signed [rrpc_pkg::COORD_W-1:0] px, py, pz,
				logic [rrpc_pkg::TAG_W-1:0] tag);
			verdict_t v;
			v.in_region = predict_inside(px, py, pz);
			v.tag       = tag;
			awaited.push_back(v);
		endfunction

		task check_result(logic in_region, logic [rrpc_pkg::TAG_W-1:0] tag);
			verdict_t v;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result tag %0h inside %0b", tag, in_region));
				return;
			end
			v = awaited.pop_front();
			if (in_region !== v.in_region)
				report($sformatf("tag %0h: inside %0b, expected %0b", v.tag, in_region,
					v.in_region));
			if (tag !== v.tag)
				report($sformatf("tag_out %0h, expected %0h", tag, v.tag));
		endtask

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rrpc_point_if  pt_if();
	rrpc_result_if res_if();
	rrpc_cfg_if    cfg_if();

	rotated_region_point_classifier u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.point  (pt_if),
		.result (res_if)
	);

	verdict_board_t chk = new();
	bit             no_idle;
	longint         ctr_x, ctr_y, ctr_z;
	longint         half_x, half_y, half_z;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic int idle_cycles();
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic send_point(logic [rrpc_pkg::COORD_W-1:0] px, py, pz,
			logic [rrpc_pkg::TAG_W-1:0] tag);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			pt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt_if.valid       <= 1'b1;
		pt_if.point_x     <= px;
		pt_if.point_y     <= py;
		pt_if.point_z     <= pz;
		pt_if.element_tag <= tag;
		@(posedge clk);
		while (!pt_if.ready) @(posedge clk);
		chk.note_point(px, py, pz, tag);
	endtask

	task automatic drain();
		if (pt_if.valid) pt_if.valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [rrpc_pkg::CFG_IDX_W-1:0] idx,
			logic [rrpc_pkg::CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		chk.set_reg(idx, val);
	endtask

	task automatic end_writes();
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [rrpc_pkg::CFG_DATA_W-1:0] junk_hi(logic [31:0] val);
		return {16'($urandom()), val};
	endfunction

	function automatic longint spread(longint h);
		return longint'($urandom_range(0, 32'(2 * h))) - h;
	endfunction

	// pick a half-length for one axis and return the reciprocal to program
	task automatic pick_axis(output longint h, output logic [rrpc_pkg::RECIP_W-1:0] recip);
		int sel;
		sel = $urandom_range(0, 11);
		h   = 1000;
		if (sel == 0) recip = '0;
		else if (sel == 1) recip = 48'({$urandom(), $urandom()});
		else begin
			h     = 1 + ($urandom() & ((32'd1 << $urandom_range(0, 20)) - 1));
			recip = 48'((64'd1 << 48) / h);
		end
	endtask

	task automatic directed_points();
		send_point(0, 0, 0, 24'h000000);
		send_point(1000, 0, 0, 24'h000001);
		send_point(1001, 0, 0, 24'h000002);
		send_point(0, -1000, 0, 24'h000003);
		send_point(0, 0, 1000, 24'h000004);
		send_point(0, 0, -1001, 24'h000005);
		send_point(707, 707, 0, 24'h000006);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h000000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 24'hAAAAAA);

		drain();
		write_reg(rrpc_pkg::REG_SHAPE, rrpc_pkg::CFG_DATA_W'(rrpc_pkg::SHAPE_BOX));
		end_writes();
		send_point(1000, -1000, 1000, 24'h555555);
		send_point(1000, 1000, 1001, 24'h000010);

		drain();
		write_reg(rrpc_pkg::REG_SHAPE, rrpc_pkg::CFG_DATA_W'(rrpc_pkg::SHAPE_CYLINDER));
		end_writes();
		send_point(700, 700, 1000, 24'h000011);
		send_point(0, 0, -1000, 24'h000012);
		send_point(800, 800, 0, 24'h000013);

		// code 3 is no region at all
		drain();
		write_reg(rrpc_pkg::REG_SHAPE, rrpc_pkg::CFG_DATA_W'(SHAPE_UNUSED));
		end_writes();
		send_point(0, 0, 0, 24'h000014);

		// zero reciprocals: no axis can exclude
		drain();
		write_reg(rrpc_pkg::REG_SHAPE, rrpc_pkg::CFG_DATA_W'(rrpc_pkg::SHAPE_BOX));
		write_reg(rrpc_pkg::REG_RECIP_X, '0);
		write_reg(rrpc_pkg::REG_RECIP_Y, '0);
		write_reg(rrpc_pkg::REG_RECIP_Z, '0);
		end_writes();
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h000015);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h000016);

		// quarter turn, narrow y
		drain();
		write_reg(rrpc_pkg::REG_ROTATION, rrpc_pkg::CFG_DATA_W'(32'h0000_4000));
		write_reg(rrpc_pkg::REG_RECIP_X, rrpc_pkg::RECIP_RESET);
		write_reg(rrpc_pkg::REG_RECIP_Y, 48'((64'd1 << 48) / 10));
		write_reg(rrpc_pkg::REG_RECIP_Z, rrpc_pkg::RECIP_RESET);
		end_writes();
		send_point(0, 1000, 0, 24'h000017);
		send_point(1000, 0, 0, 24'h000018);
	endtask

	task automatic configure(int ph);
		logic [rrpc_pkg::SHAPE_W-1:0] shape;
		logic [rrpc_pkg::RECIP_W-1:0] rcx, rcy, rcz;
		logic [rrpc_pkg::ROT_W-1:0]   rot;
		int                           c, s, mode;
		shape = (ph < 4) ? rrpc_pkg::SHAPE_W'(ph) :
			(($urandom_range(0, 9) == 0) ? SHAPE_UNUSED :
				rrpc_pkg::SHAPE_W'($urandom_range(0, 2)));
		if (ph == 0) begin
			ctr_x = -64'sd2147483648; ctr_y = ctr_x; ctr_z = ctr_x;
			rot = 32'h8000_8000;
			rcx = '1; rcy = '1; rcz = '1;
			half_x = 1; half_y = 1; half_z = 1;
		end else if (ph == 1) begin
			ctr_x = 64'sd2147483647; ctr_y = ctr_x; ctr_z = ctr_x;
			rot = 32'h7FFF_7FFF;
			rcx = 48'd1; rcy = 48'd1; rcz = 48'd1;
			half_x = 1000; half_y = 1000; half_z = 1000;
		end else begin
			mode = $urandom_range(0, 3);
			if (mode == 0) begin
				ctr_x = 0; ctr_y = 0; ctr_z = 0;
			end else if (mode == 1) begin
				ctr_x = longint'($signed(32'($urandom())));
				ctr_y = longint'($signed(32'($urandom())));
				ctr_z = longint'($signed(32'($urandom())));
			end else begin
				ctr_x = longint'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
				ctr_y = longint'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
				ctr_z = longint'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
			end
			if ($urandom_range(0, 4) == 0) rot = $urandom();
			else begin
				c = $urandom_range(0, 16384);
				s = int'($sqrt(real'(268435456 - c * c)));
				if ($urandom_range(0, 1)) c = -c;
				if ($urandom_range(0, 1)) s = -s;
				rot = {16'(c), 16'(s)};
			end
			pick_axis(half_x, rcx);
			pick_axis(half_y, rcy);
			pick_axis(half_z, rcz);
		end
		write_reg(rrpc_pkg::REG_SHAPE, {46'($urandom()), shape});
		write_reg(rrpc_pkg::REG_CENTRE_X, junk_hi(32'(ctr_x)));
		write_reg(rrpc_pkg::REG_CENTRE_Y, junk_hi(32'(ctr_y)));
		write_reg(rrpc_pkg::REG_CENTRE_Z, junk_hi(32'(ctr_z)));
		write_reg(rrpc_pkg::REG_ROTATION, junk_hi(rot));
		write_reg(rrpc_pkg::REG_RECIP_X, rcx);
		write_reg(rrpc_pkg::REG_RECIP_Y, rcy);
		write_reg(rrpc_pkg::REG_RECIP_Z, rcz);
		end_writes();
	endtask

	task automatic send_random();
		longint                       hxy, span;
		logic [rrpc_pkg::COORD_W-1:0] px, py, pz;
		int                           kind;
		kind = $urandom_range(0, 9);
		hxy  = (half_x > half_y) ? half_x : half_y;
		if (kind < 2) begin
			px = $urandom();
			py = $urandom();
			pz = $urandom();
		end else begin
			span = (kind < 7) ? 1 : 2;
			px = 32'(ctr_x + spread(hxy * span));
			py = 32'(ctr_y + spread(hxy * span));
			pz = 32'(ctr_z + spread(half_z * span));
		end
		send_point(px, py, pz, 24'($urandom()));
	endtask

	// result side
	initial begin
		int stall;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			chk.check_result(res_if.inside_res, res_if.tag_out);
		end
	end

	initial begin
		arst_n            = 1'b0;
		no_idle           = 1'b0;
		pt_if.valid       = 1'b0;
		pt_if.point_x     = '0;
		pt_if.point_y     = '0;
		pt_if.point_z     = '0;
		pt_if.element_tag = '0;
		res_if.ready      = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = '0;
		cfg_if.data       = '0;
		ctr_x = 0; ctr_y = 0; ctr_z = 0;
		half_x = 1000; half_y = 1000; half_z = 1000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_points();

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			configure(ph);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 82; i++) begin
				if ($urandom_range(0, 49) == 0) drain();
				send_random();
			end
		end

		drain();
		repeat (4 * rrpc_pkg::PIPE_DEPTH) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
